@@ rtl/qte_pkg.sv @@
// Shared types, constants and helper functions of the quaternion to Euler converter.
package qte_pkg;

    localparam int QUAT_BITS         = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam int COMP_W    = 32;
    localparam int PROD_W    = 2 * COMP_W;
    localparam int ARG_W     = 64;
    localparam int ANG_FRAC  = 28;
    localparam int ANG_W     = 36;
    localparam int CORDIC_W  = 45;
    localparam int NORM_MSB  = 40;
    localparam int POS_W     = $clog2(ARG_W);
    localparam int SQRT_STEPS = 31;
    localparam int RAD_W     = 2 * SQRT_STEPS;
    localparam int ROOT_W    = SQRT_STEPS;
    localparam int REM_W     = ROOT_W + 4;
    localparam int LIMIT_W   = 31;
    localparam int LIM_SHIFT = 30;
    localparam int S_SHIFT   = 29;

    localparam int QUAT_UP = (QUAT_BITS - 1 <= 30) ? 30 - (QUAT_BITS - 1) : 0;
    localparam int QUAT_DN = (QUAT_BITS - 1 <= 30) ? 0 : (QUAT_BITS - 1) - 30;

    localparam logic [LIMIT_W-1:0]      LIMIT_RESET = 31'd536869838;
    localparam logic signed [ANG_W-1:0] PI_Q28      = 36'sd843314857;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q28 = 36'sd421657428;
    localparam logic signed [PROD_W-1:0] ONE_Q60    = 64'sd1 <<< 60;
    localparam logic signed [PROD_W-1:0] ONE_Q30    = 64'sd1 <<< 30;

    localparam logic [1:0] LOCK_NONE  = 2'd0;
    localparam logic [1:0] LOCK_NORTH = 2'd1;
    localparam logic [1:0] LOCK_SOUTH = 2'd2;

    typedef struct packed {
        logic signed [QUAT_BITS-1:0] quat_x;
        logic signed [QUAT_BITS-1:0] quat_y;
        logic signed [QUAT_BITS-1:0] quat_z;
        logic signed [QUAT_BITS-1:0] quat_w;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] heading;
        logic signed [15:0] attitude;
        logic signed [15:0] bank;
        logic [1:0]         lock_case;
    } out_word_t;

    // Component to 30 fraction bits.
    function automatic logic signed [COMP_W-1:0] comp_q30(input logic signed [QUAT_BITS-1:0] q);
        logic signed [63:0] e;
        e = 64'(q);
        e = (e <<< QUAT_UP) >>> QUAT_DN;
        return COMP_W'(e);
    endfunction

    // Arctangent of 2^-i with 28 fraction bits.
    function automatic logic [ANG_FRAC+1:0] atan_entry(input int i);
        logic [ANG_FRAC+1:0] r;
        case (i)
            0: r = 30'd210828714;
            1: r = 30'd124459458;
            2: r = 30'd65760960;
            3: r = 30'd33381290;
            4: r = 30'd16755422;
            5: r = 30'd8385879;
            6: r = 30'd4193963;
            7: r = 30'd2097109;
            8: r = 30'd1048571;
            9: r = 30'd524287;
            default: r = (i <= ANG_FRAC) ? (ANG_FRAC+2)'(64'd1 << (ANG_FRAC - i)) : '0;
        endcase
        return r;
    endfunction

    // Q28 angle to Q3.12, round half up, saturate.
    function automatic logic signed [15:0] to_q312(input logic signed [ANG_W+1:0] a);
        logic signed [ANG_W+2:0] r;
        r = ((ANG_W+3)'(a) + (ANG_W+3)'(32768)) >>> 16;
        if (r > (ANG_W+3)'(32767)) begin
            return 16'sh7FFF;
        end else if (r < -(ANG_W+3)'(32768)) begin
            return 16'sh8000;
        end else begin
            return r[15:0];
        end
    endfunction

endpackage

@@ rtl/qte_isqrt.sv @@
// Pipelined integer square root, one result bit per stage, with sideband.
module qte_isqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [qte_pkg::RAD_W-1:0] rad_i,
    input  logic [SIDE_W-1:0]         side_i,
    output logic                      out_valid,
    output logic [qte_pkg::ROOT_W-1:0] root_o,
    output logic [SIDE_W-1:0]         side_o
);
    import qte_pkg::*;

    localparam int N = SQRT_STEPS;

    logic              vld_reg  [0:N-1];
    logic [RAD_W-1:0]  rad_reg  [0:N-1];
    logic [REM_W-1:0]  rem_reg  [0:N-1];
    logic [ROOT_W-1:0] root_reg [0:N-1];
    logic [SIDE_W-1:0] side_reg [0:N-1];

    logic              vld_next  [0:N-1];
    logic [RAD_W-1:0]  rad_next  [0:N-1];
    logic [REM_W-1:0]  rem_next  [0:N-1];
    logic [ROOT_W-1:0] root_next [0:N-1];
    logic [SIDE_W-1:0] side_next [0:N-1];

    always_comb begin
        for (int k = 0; k < N; k++) begin
            logic [RAD_W-1:0]  p_rad;
            logic [REM_W-1:0]  p_rem;
            logic [ROOT_W-1:0] p_root;
            logic [REM_W-1:0]  cur;
            logic [REM_W-1:0]  trial;
            if (k == 0) begin
                vld_next[k]  = in_valid;
                side_next[k] = side_i;
                p_rad  = rad_i;
                p_rem  = '0;
                p_root = '0;
            end else begin
                vld_next[k]  = vld_reg[k-1];
                side_next[k] = side_reg[k-1];
                p_rad  = rad_reg[k-1];
                p_rem  = rem_reg[k-1];
                p_root = root_reg[k-1];
            end
            cur   = {p_rem[REM_W-3:0], p_rad[RAD_W-1 -: 2]};
            trial = REM_W'({p_root, 2'b01});
            if (cur >= trial) begin
                rem_next[k]  = cur - trial;
                root_next[k] = {p_root[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next[k]  = cur;
                root_next[k] = {p_root[ROOT_W-2:0], 1'b0};
            end
            rad_next[k] = p_rad << 2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < N; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            for (int k = 0; k < N; k++) begin
                vld_reg[k] <= vld_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < N; k++) begin
                rad_reg[k]  <= rad_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                side_reg[k] <= side_next[k];
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign root_o    = root_reg[N-1];
    assign side_o    = side_reg[N-1];

endmodule

@@ rtl/qte_cordic.sv @@
// Pipelined vectoring CORDIC atan2 with quadrant fold and magnitude normalization.
module qte_cordic #(
    parameter int STAGES = qte_pkg::CORDIC_STAGES_DEF,
    parameter int SIDE_W = 1
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic signed [qte_pkg::ARG_W-1:0] y_i,
    input  logic signed [qte_pkg::ARG_W-1:0] x_i,
    input  logic [SIDE_W-1:0]                side_i,
    output logic                             out_valid,
    output logic signed [qte_pkg::ANG_W-1:0] angle_o,
    output logic [SIDE_W-1:0]                side_o
);
    import qte_pkg::*;

    // fold
    logic                    f1_vld_reg, f1_zero_reg;
    logic signed [ARG_W-1:0] f1_x_reg, f1_y_reg;
    logic signed [ANG_W-1:0] f1_base_reg;
    logic [SIDE_W-1:0]       f1_side_reg;
    logic                    f1_neg;
    // magnitude
    logic                    f2_vld_reg, f2_zero_reg;
    logic signed [ARG_W-1:0] f2_x_reg, f2_y_reg;
    logic [ARG_W-1:0]        f2_mag_reg, f2_mag_next, ax, ay;
    logic signed [ANG_W-1:0] f2_base_reg;
    logic [SIDE_W-1:0]       f2_side_reg;
    // leading one
    logic                    f3_vld_reg, f3_zero_reg;
    logic signed [ARG_W-1:0] f3_x_reg, f3_y_reg;
    logic [POS_W-1:0]        f3_pos_reg, f3_pos_next;
    logic signed [ANG_W-1:0] f3_base_reg;
    logic [SIDE_W-1:0]       f3_side_reg;
    // normalize
    logic                       f4_vld_reg, f4_zero_reg;
    logic signed [CORDIC_W-1:0] f4_x_reg, f4_y_reg, f4_x_next, f4_y_next;
    logic signed [ANG_W-1:0]    f4_base_reg;
    logic [SIDE_W-1:0]          f4_side_reg;

    assign f1_neg = x_i[ARG_W-1];
    assign ax = f1_x_reg[ARG_W-1] ? ARG_W'(-f1_x_reg) : ARG_W'(f1_x_reg);
    assign ay = f1_y_reg[ARG_W-1] ? ARG_W'(-f1_y_reg) : ARG_W'(f1_y_reg);
    assign f2_mag_next = (ax > ay) ? ax : ay;

    always_comb begin
        f3_pos_next = '0;
        for (int b = 0; b < ARG_W; b++) begin
            if (f2_mag_reg[b]) begin
                f3_pos_next = POS_W'(b);
            end
        end
    end

    always_comb begin
        logic [POS_W-1:0] sh;
        if (f3_pos_reg >= POS_W'(NORM_MSB)) begin
            sh = f3_pos_reg - POS_W'(NORM_MSB);
            f4_x_next = CORDIC_W'(f3_x_reg >>> sh);
            f4_y_next = CORDIC_W'(f3_y_reg >>> sh);
        end else begin
            sh = POS_W'(NORM_MSB) - f3_pos_reg;
            f4_x_next = CORDIC_W'(f3_x_reg <<< sh);
            f4_y_next = CORDIC_W'(f3_y_reg <<< sh);
        end
    end

    logic                       it_vld_reg  [0:STAGES-1];
    logic                       it_zero_reg [0:STAGES-1];
    logic signed [CORDIC_W-1:0] it_x_reg    [0:STAGES-1];
    logic signed [CORDIC_W-1:0] it_y_reg    [0:STAGES-1];
    logic signed [ANG_W-1:0]    it_z_reg    [0:STAGES-1];
    logic [SIDE_W-1:0]          it_side_reg [0:STAGES-1];

    logic                       it_vld_next  [0:STAGES-1];
    logic                       it_zero_next [0:STAGES-1];
    logic signed [CORDIC_W-1:0] it_x_next    [0:STAGES-1];
    logic signed [CORDIC_W-1:0] it_y_next    [0:STAGES-1];
    logic signed [ANG_W-1:0]    it_z_next    [0:STAGES-1];
    logic [SIDE_W-1:0]          it_side_next [0:STAGES-1];

    always_comb begin
        for (int k = 0; k < STAGES; k++) begin
            logic signed [CORDIC_W-1:0] px, py, dx, dy;
            logic signed [ANG_W-1:0]    pz, da;
            if (k == 0) begin
                it_vld_next[k]  = f4_vld_reg;
                it_zero_next[k] = f4_zero_reg;
                it_side_next[k] = f4_side_reg;
                px = f4_x_reg;
                py = f4_y_reg;
                pz = f4_base_reg;
            end else begin
                it_vld_next[k]  = it_vld_reg[k-1];
                it_zero_next[k] = it_zero_reg[k-1];
                it_side_next[k] = it_side_reg[k-1];
                px = it_x_reg[k-1];
                py = it_y_reg[k-1];
                pz = it_z_reg[k-1];
            end
            dx = py >>> k;
            dy = px >>> k;
            da = $signed(ANG_W'(atan_entry(k)));
            if (!py[CORDIC_W-1]) begin
                it_x_next[k] = px + dx;
                it_y_next[k] = py - dy;
                it_z_next[k] = pz + da;
            end else begin
                it_x_next[k] = px - dx;
                it_y_next[k] = py + dy;
                it_z_next[k] = pz - da;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
            f3_vld_reg <= 1'b0;
            f4_vld_reg <= 1'b0;
            for (int k = 0; k < STAGES; k++) begin
                it_vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            f1_vld_reg <= in_valid;
            f2_vld_reg <= f1_vld_reg;
            f3_vld_reg <= f2_vld_reg;
            f4_vld_reg <= f3_vld_reg;
            for (int k = 0; k < STAGES; k++) begin
                it_vld_reg[k] <= it_vld_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_x_reg    <= f1_neg ? -x_i : x_i;
            f1_y_reg    <= f1_neg ? -y_i : y_i;
            f1_base_reg <= f1_neg ? (y_i[ARG_W-1] ? -PI_Q28 : PI_Q28) : '0;
            f1_zero_reg <= (x_i == '0) && (y_i == '0);
            f1_side_reg <= side_i;

            f2_x_reg    <= f1_x_reg;
            f2_y_reg    <= f1_y_reg;
            f2_mag_reg  <= f2_mag_next;
            f2_base_reg <= f1_base_reg;
            f2_zero_reg <= f1_zero_reg;
            f2_side_reg <= f1_side_reg;

            f3_x_reg    <= f2_x_reg;
            f3_y_reg    <= f2_y_reg;
            f3_pos_reg  <= f3_pos_next;
            f3_base_reg <= f2_base_reg;
            f3_zero_reg <= f2_zero_reg;
            f3_side_reg <= f2_side_reg;

            f4_x_reg    <= f4_x_next;
            f4_y_reg    <= f4_y_next;
            f4_base_reg <= f3_base_reg;
            f4_zero_reg <= f3_zero_reg;
            f4_side_reg <= f3_side_reg;

            for (int k = 0; k < STAGES; k++) begin
                it_x_reg[k]    <= it_x_next[k];
                it_y_reg[k]    <= it_y_next[k];
                it_z_reg[k]    <= it_z_next[k];
                it_zero_reg[k] <= it_zero_next[k];
                it_side_reg[k] <= it_side_next[k];
            end
        end
    end

    assign out_valid = it_vld_reg[STAGES-1];
    assign angle_o   = it_zero_reg[STAGES-1] ? '0 : it_z_reg[STAGES-1];
    assign side_o    = it_side_reg[STAGES-1];

endmodule

@@ rtl/quaternion_to_euler.sv @@
// Quaternion to heading / attitude / bank converter, top level.
// Throughput: one word per cycle; every stage is registered and the whole pipe
// advances together whenever the output register is empty or being taken.
// Reset clears all valid bits and loads limit_reg with 0.499999 in unsigned Q1.30.
module quaternion_to_euler #(
    parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  qte_pkg::in_word_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output qte_pkg::out_word_t            m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [qte_pkg::LIMIT_W-1:0]   cfg_data
);
    import qte_pkg::*;

    typedef struct packed {
        logic signed [ARG_W-1:0]  head_y;
        logic signed [ARG_W-1:0]  head_x;
        logic signed [ARG_W-1:0]  bank_y;
        logic signed [ARG_W-1:0]  bank_x;
        logic signed [COMP_W-1:0] s;
        logic [1:0]               lock;
    } sqrt_side_t;

    localparam logic signed [15:0] ATT_NORTH_Q312 = to_q312((ANG_W+2)'(HALF_PI_Q28));
    localparam logic signed [15:0] ATT_SOUTH_Q312 = to_q312(-(ANG_W+2)'(HALF_PI_Q28));

    logic en;
    logic [LIMIT_W-1:0] limit_reg;

    logic                     v1_reg;
    logic signed [COMP_W-1:0] x1_reg, y1_reg, z1_reg, w1_reg;

    logic                     v2_reg;
    logic signed [PROD_W-1:0] xy2_reg, zw2_reg, xw2_reg, yz2_reg, yw2_reg, xz2_reg;
    logic signed [PROD_W-1:0] xx2_reg, yy2_reg, zz2_reg;
    logic signed [COMP_W-1:0] x2_reg, w2_reg;

    logic                     v3_reg;
    sqrt_side_t               side3_reg, side3_next;
    logic signed [PROD_W-1:0] t3, lim3, ts3;

    logic                     v4_reg;
    sqrt_side_t               side4_reg;
    logic [RAD_W-1:0]         rad4_reg;
    logic signed [PROD_W-1:0] ss4;

    logic              v5;
    logic [ROOT_W-1:0] root5;
    sqrt_side_t        side5;

    logic                    cv_head, cv_att, cv_bank;
    logic signed [ANG_W-1:0] head_ang, att_ang, bank_ang;
    logic [1:0]              lock6;
    logic [1:0]              lock_head, lock_bank;

    logic                      m_valid_reg;
    out_word_t                 out_reg, out_next;
    logic signed [ANG_W+1:0]   bank2;

    assign en        = !m_valid_reg || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_valid) begin
            limit_reg <= cfg_data;
        end
    end

    // gimbal test, asin argument, atan2 operands
    always_comb begin
        t3   = xy2_reg + zw2_reg;
        lim3 = $signed({(PROD_W-LIMIT_W-LIM_SHIFT)'(0), limit_reg, LIM_SHIFT'(0)});
        ts3  = t3 >>> S_SHIFT;
        if (ts3 > ONE_Q30) begin
            side3_next.s = COMP_W'(ONE_Q30);
        end else if (ts3 < -ONE_Q30) begin
            side3_next.s = COMP_W'(-ONE_Q30);
        end else begin
            side3_next.s = COMP_W'(ts3);
        end
        side3_next.head_y = (xw2_reg - yz2_reg) <<< 1;
        side3_next.head_x = ONE_Q60 - ((xx2_reg + zz2_reg) <<< 1);
        if (t3 > lim3) begin
            side3_next.lock = LOCK_NORTH;
        end else if (t3 < -lim3) begin
            side3_next.lock = LOCK_SOUTH;
        end else begin
            side3_next.lock = LOCK_NONE;
        end
        if (side3_next.lock != LOCK_NONE) begin
            side3_next.bank_y = ARG_W'(x2_reg);
            side3_next.bank_x = ARG_W'(w2_reg);
        end else begin
            side3_next.bank_y = (yw2_reg - xz2_reg) <<< 1;
            side3_next.bank_x = ONE_Q60 - ((yy2_reg + zz2_reg) <<< 1);
        end
    end

    assign ss4 = side3_reg.s * side3_reg.s;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg <= comp_q30(s_data.quat_x);
            y1_reg <= comp_q30(s_data.quat_y);
            z1_reg <= comp_q30(s_data.quat_z);
            w1_reg <= comp_q30(s_data.quat_w);

            xy2_reg <= x1_reg * y1_reg;
            zw2_reg <= z1_reg * w1_reg;
            xw2_reg <= x1_reg * w1_reg;
            yz2_reg <= y1_reg * z1_reg;
            yw2_reg <= y1_reg * w1_reg;
            xz2_reg <= x1_reg * z1_reg;
            xx2_reg <= x1_reg * x1_reg;
            yy2_reg <= y1_reg * y1_reg;
            zz2_reg <= z1_reg * z1_reg;
            x2_reg  <= x1_reg;
            w2_reg  <= w1_reg;

            side3_reg <= side3_next;

            side4_reg <= side3_reg;
            rad4_reg  <= RAD_W'(ONE_Q60 - ss4);
        end
    end

    qte_isqrt #(
        .SIDE_W ($bits(sqrt_side_t))
    ) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v4_reg),
        .rad_i     (rad4_reg),
        .side_i    (side4_reg),
        .out_valid (v5),
        .root_o    (root5),
        .side_o    (side5)
    );

    qte_cordic #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (2)
    ) u_cordic_head (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v5),
        .y_i       (side5.head_y),
        .x_i       (side5.head_x),
        .side_i    (side5.lock),
        .out_valid (cv_head),
        .angle_o   (head_ang),
        .side_o    (lock_head)
    );

    qte_cordic #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (2)
    ) u_cordic_att (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v5),
        .y_i       (ARG_W'(side5.s)),
        .x_i       ($signed(ARG_W'(root5))),
        .side_i    (side5.lock),
        .out_valid (cv_att),
        .angle_o   (att_ang),
        .side_o    (lock6)
    );

    qte_cordic #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (2)
    ) u_cordic_bank (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v5),
        .y_i       (side5.bank_y),
        .x_i       (side5.bank_x),
        .side_i    (side5.lock),
        .out_valid (cv_bank),
        .angle_o   (bank_ang),
        .side_o    (lock_bank)
    );

    // output formatting
    always_comb begin
        bank2 = (ANG_W+2)'(bank_ang) <<< 1;
        out_next.lock_case = lock6;
        case (lock6)
            LOCK_NORTH: begin
                out_next.heading  = '0;
                out_next.attitude = ATT_NORTH_Q312;
                out_next.bank     = to_q312(bank2);
            end
            LOCK_SOUTH: begin
                out_next.heading  = '0;
                out_next.attitude = ATT_SOUTH_Q312;
                out_next.bank     = to_q312(-bank2);
            end
            default: begin
                out_next.heading  = to_q312((ANG_W+2)'(head_ang));
                out_next.attitude = to_q312((ANG_W+2)'(att_ang));
                out_next.bank     = to_q312((ANG_W+2)'(bank_ang));
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= cv_head && cv_att && cv_bank;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_cfg_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> limit_reg == $past(cfg_data))
        else $error("gimbal limit not loaded");

    a_north: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.lock_case == LOCK_NORTH
        |-> m_data.heading == 16'sd0 && m_data.attitude == ATT_NORTH_Q312)
        else $error("north lock word malformed");

    a_south: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.lock_case == LOCK_SOUTH
        |-> m_data.heading == 16'sd0 && m_data.attitude == ATT_SOUTH_Q312)
        else $error("south lock word malformed");

    a_lanes: assert property (@(posedge aclk) disable iff (!aresetn)
        cv_head == cv_att && cv_att == cv_bank
        && (!cv_att || (lock_head == lock6 && lock_bank == lock6)))
        else $error("cordic lanes out of step");

endmodule

@@ tb/qte_checker.sv @@
// Scoreboard for the quaternion to Euler converter: predicts each result word and compares.
`timescale 1ns / 1ps
module qte_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  qte_pkg::in_word_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  qte_pkg::out_word_t m_data,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [30:0]        cfg_data,
    output int                 fail_count,
    output int                 pending
);
    import qte_pkg::*;

    localparam longint PI_FX      = 64'sd843314857;
    localparam longint HALF_PI_FX = 64'sd421657428;
    localparam longint UNIT_Q60   = 64'sd1 <<< 60;
    localparam longint UNIT_Q30   = 64'sd1 <<< 30;
    localparam longint ATAN_TAB [10] = '{210828714, 124459458, 65760960, 33381290,
                                         16755422, 8385879, 4193963, 2097109,
                                         1048571, 524287};
    localparam int     EXP_DEPTH  = 64;

    logic [30:0] lock_limit;
    out_word_t   exp_mem [0:EXP_DEPTH-1];
    logic [5:0]  wr_ptr, rd_ptr;

    function automatic longint angle_of(longint y, longint x);
        longint base, z, mag, dx, dy, step;
        base = 0;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            base = (y >= 0) ? PI_FX : -PI_FX;
            x = -x;
            y = -y;
        end
        mag = (x < 0 ? -x : x) > (y < 0 ? -y : y) ? (x < 0 ? -x : x) : (y < 0 ? -y : y);
        while (mag >= (64'sd1 <<< 41)) begin
            x = x >>> 1;
            y = y >>> 1;
            mag = mag >>> 1;
        end
        while (mag < (64'sd1 <<< 40)) begin
            x = x * 2;
            y = y * 2;
            mag = mag * 2;
        end
        for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            step = (i < 10) ? ATAN_TAB[i] : ((64'sd1 <<< 28) >>> i);
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + step;
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - step;
            end
        end
        return base + z;
    endfunction

    function automatic longint unsigned root_of(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [15:0] round_angle(longint a);
        longint r;
        r = (a + 64'sd32768) >>> 16;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic out_word_t euler_of(in_word_t q, logic [30:0] limit);
        longint x, y, z, w, t, lim, hd, at, bk, s;
        longint unsigned c;
        out_word_t o;
        x = longint'(q.quat_x) <<< 15;
        y = longint'(q.quat_y) <<< 15;
        z = longint'(q.quat_z) <<< 15;
        w = longint'(q.quat_w) <<< 15;
        t = x * y + z * w;
        lim = longint'(limit) <<< 30;
        if (t > lim) begin
            hd = 0;
            at = HALF_PI_FX;
            bk = 2 * angle_of(x, w);
            o.lock_case = LOCK_NORTH;
        end else if (t < -lim) begin
            hd = 0;
            at = -HALF_PI_FX;
            bk = -2 * angle_of(x, w);
            o.lock_case = LOCK_SOUTH;
        end else begin
            s = (2 * t) >>> 30;
            if (s > UNIT_Q30) s = UNIT_Q30;
            if (s < -UNIT_Q30) s = -UNIT_Q30;
            c = root_of(longint'(UNIT_Q60 - s * s));
            hd = angle_of(2 * (x * w - y * z), UNIT_Q60 - 2 * (x * x + z * z));
            at = angle_of(s, longint'(c));
            bk = angle_of(2 * (y * w - x * z), UNIT_Q60 - 2 * (y * y + z * z));
            o.lock_case = LOCK_NONE;
        end
        o.heading  = round_angle(hd);
        o.attitude = round_angle(at);
        o.bank     = round_angle(bk);
        return o;
    endfunction

    assign pending = int'(6'(wr_ptr - rd_ptr));

    always @(posedge aclk) begin
        out_word_t e;
        if (!aresetn) begin
            lock_limit <= LIMIT_RESET;
            wr_ptr <= '0;
            rd_ptr <= '0;
            fail_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) lock_limit <= cfg_data;
            if (s_valid && s_ready) begin
                exp_mem[wr_ptr] <= euler_of(s_data, lock_limit);
                wr_ptr <= wr_ptr + 6'd1;
            end
            if (m_valid && m_ready) begin
                if (wr_ptr == rd_ptr) begin
                    $display("%0t: unexpected word %h", $time, m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    e = exp_mem[rd_ptr];
                    rd_ptr <= rd_ptr + 6'd1;
                    if (e !== m_data) begin
                        $display("%0t: mismatch exp h=%0d a=%0d b=%0d l=%0d got h=%0d a=%0d b=%0d l=%0d",
                                 $time, e.heading, e.attitude, e.bank, e.lock_case,
                                 m_data.heading, m_data.attitude, m_data.bank,
                                 m_data.lock_case);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

@@ tb/tb_quaternion_to_euler.sv @@
// Top of the quaternion to Euler testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_quaternion_to_euler;
    import qte_pkg::*;

    localparam int STALL_LIMIT = 3000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_word_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_word_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [30:0] cfg_data = '0;
    int          fail_count, pending;
    bit          burst = 0;
    int          quiet = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    quaternion_to_euler uut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .cfg_valid, .cfg_ready, .cfg_data
    );

    qte_checker chk (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .cfg_valid, .cfg_ready, .cfg_data, .fail_count, .pending
    );

    // no-progress watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
            || pending == 0 && !s_valid && !cfg_valid) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("FAIL quaternion_to_euler");
            $finish;
        end
    end

    // result side, with one long hold-off so the pipe fills
    initial begin
        int gap, taken;
        bit took;
        taken = 0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            gap = burst ? 0 : $urandom_range(0, 18);
            if (taken == 120) gap = 300;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            forever begin
                #1 took = m_valid;
                @(posedge aclk);
                if (took) break;
                @(negedge aclk);
            end
            taken++;
            @(negedge aclk);
        end
    end

    task automatic send_word(in_word_t d);
        int gap;
        bit took;
        gap = burst ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  <= d;
        s_valid <= 1'b1;
        forever begin
            #1 took = s_ready;
            @(posedge aclk);
            if (took) break;
            @(negedge aclk);
        end
        @(negedge aclk);
    endtask

    task automatic write_limit(logic [30:0] v);
        bit took;
        s_valid <= 1'b0;
        wait (pending == 0);
        repeat (70) @(negedge aclk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        forever begin
            #1 took = cfg_ready;
            @(posedge aclk);
            if (took) break;
            @(negedge aclk);
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic in_word_t make_quat(int a, int b, int c, int d);
        in_word_t q;
        q.quat_x = 16'(a);
        q.quat_y = 16'(b);
        q.quat_z = 16'(c);
        q.quat_w = 16'(d);
        return q;
    endfunction

    function automatic in_word_t rand_quat();
        int kind, m;
        real v[4], n;
        kind = $urandom_range(0, 9);
        if (kind < 2) return in_word_t'({$urandom, $urandom});
        if (kind < 4) begin
            // near the poles: t close to +/-0.5 when the signs of x*y and z*w agree
            m = $urandom_range(15000, 17800);
            return make_quat($urandom_range(0, 1) ? m : -m, m,
                             $urandom_range(0, 1) ? m : -m, $urandom_range(0, 1) ? m : -m);
        end
        n = 0.0;
        for (int i = 0; i < 4; i++) begin
            v[i] = real'(int'($urandom_range(0, 65534)) - 32767);
            n = n + v[i] * v[i];
        end
        if (n < 1.0) return make_quat(0, 0, 0, 32767);
        n = $sqrt(n);
        return make_quat(int'(v[0] / n * 32767.0), int'(v[1] / n * 32767.0),
                         int'(v[2] / n * 32767.0), int'(v[3] / n * 32767.0));
    endfunction

    task automatic run_random(int n);
        for (int i = 0; i < n; i++) begin
            if (i % 60 == 30) burst = 1;
            if (i % 60 == 45) burst = 0;
            send_word(rand_quat());
        end
        burst = 0;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_word(make_quat(0, 0, 0, 0));
        send_word(make_quat(0, 0, 0, 32767));
        send_word(make_quat(0, 0, 0, -32768));
        send_word(make_quat(32767, 32767, 32767, 32767));
        send_word(make_quat(-32768, -32768, -32768, -32768));
        send_word(make_quat(16384, 16384, 16384, 16384));
        send_word(make_quat(-16384, 16384, 16384, 16384));
        send_word(make_quat(16384, 16384, -16384, 16384));
        send_word(make_quat(32767, 0, 0, 0));
        send_word(make_quat(-32768, 0, 0, -1));
        send_word(make_quat(0, 32767, 0, 0));
        send_word(make_quat(0, 0, -32768, 0));
        send_word(make_quat(23170, 0, 0, -23170));
        send_word(make_quat(0, 23170, 23170, 0));
        send_word(make_quat(-32768, 32767, -32768, 32767));
        send_word(make_quat(1, -1, 1, -1));
        send_word(make_quat(16384, 16383, 16384, 16384));
        run_random(130);

        write_limit(31'd0);
        send_word(make_quat(0, 0, 0, 32767));
        send_word(make_quat(1, 1, 0, 32767));
        send_word(make_quat(-1, 1, 0, 32767));
        run_random(80);

        write_limit(31'd1073741824);
        send_word(make_quat(-32768, -32768, -32768, -32768));
        run_random(80);

        write_limit(31'h7FFFFFFF);
        run_random(40);

        write_limit(31'($urandom_range(0, 1073741824)));
        run_random(60);

        write_limit(LIMIT_RESET);
        run_random(40);

        s_valid <= 1'b0;
        wait (pending == 0);
        repeat (80) @(posedge aclk);
        if (fail_count == 0) $display("PASS quaternion_to_euler");
        else $display("FAIL quaternion_to_euler");
        $finish;
    end
endmodule
